@@ hw/rtl/isfu_pkg.sv @@
package isfu_pkg;

	localparam int LATTICE_SIDE_DEF = 64;

	localparam int OP_W       = 2;
	localparam int COORD_W    = 6;
	localparam int COORD_SPAN = 2 ** COORD_W;
	localparam int RAND_W     = 16;
	localparam int PROB_W     = 16;
	localparam int DE_W       = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_MINUS8 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MINUS4 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLUS4  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLUS8  = 2'd3;

	localparam logic [PROB_W-1:0] PROB_MINUS8_RST = 16'd65479;
	localparam logic [PROB_W-1:0] PROB_MINUS4_RST = 16'd63662;
	localparam logic [PROB_W-1:0] PROB_PLUS4_RST  = 16'd1874;
	localparam logic [PROB_W-1:0] PROB_PLUS8_RST  = 16'd57;
	localparam logic [PROB_W-1:0] PROB_ZERO       = 16'd32768;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_DN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic accept;
		logic rd_dn;
		logic exec;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
	} status_t;

endpackage

@@ hw/rtl/isfu_if.sv @@
interface isfu_in_if;
	logic                               valid;
	logic                               ready;
	logic [isfu_pkg::OP_W-1:0]          operation;
	logic [isfu_pkg::COORD_W-1:0]       row;
	logic [isfu_pkg::COORD_W-1:0]       column;
	logic                               spin_in;
	logic [isfu_pkg::RAND_W-1:0]        random_value;

	modport source (output valid, operation, row, column, spin_in, random_value, input ready);
	modport sink (input valid, operation, row, column, spin_in, random_value, output ready);
endinterface

interface isfu_out_if;
	logic                               valid;
	logic                               ready;
	logic                               spin_out;
	logic                               flipped;
	logic signed [isfu_pkg::DE_W-1:0]   energy_change;

	modport source (output valid, spin_out, flipped, energy_change, input ready);
	modport sink (input valid, spin_out, flipped, energy_change, output ready);
endinterface

@@ hw/rtl/isfu_ram.sv @@
module isfu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic [WIDTH-1:0]                         rdata_a,
	input  logic                                     re_b,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

@@ hw/rtl/isfu_dp.sv @@
module isfu_dp #(
	parameter int LATTICE_SIDE = isfu_pkg::LATTICE_SIDE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  isfu_pkg::cmd_t                        cmd,
	output isfu_pkg::status_t                     status,
	input  logic                                  cfg_we,
	input  logic [isfu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [isfu_pkg::PROB_W-1:0]           cfg_data,
	input  logic [isfu_pkg::OP_W-1:0]             operation,
	input  logic [isfu_pkg::COORD_W-1:0]          row,
	input  logic [isfu_pkg::COORD_W-1:0]          column,
	input  logic                                  spin_in,
	input  logic [isfu_pkg::RAND_W-1:0]           random_value,
	output logic                                  spin_out,
	output logic                                  flipped,
	output logic signed [isfu_pkg::DE_W-1:0]      energy_change
);

	localparam int IDX_W = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(LATTICE_SIDE - 1);

	// coordinate reduction modulo the lattice side
	logic [IDX_W-1:0] red_tbl [isfu_pkg::COORD_SPAN];
	for (genvar i = 0; i < isfu_pkg::COORD_SPAN; i++) begin : g_red
		assign red_tbl[i] = IDX_W'(i % LATTICE_SIDE);
	end

	logic [isfu_pkg::PROB_W-1:0] prob_minus8_q, prob_minus4_q, prob_plus4_q, prob_plus8_q;
	logic [isfu_pkg::OP_W-1:0]   op_q;
	logic [IDX_W-1:0]            row_q, col_q, clr_cnt_q;
	logic                        spin_in_q;
	logic [isfu_pkg::RAND_W-1:0] rnd_q;
	logic [LATTICE_SIDE-1:0]     up_q;
	logic                        spin_out_q, flipped_q;
	logic signed [isfu_pkg::DE_W-1:0] de_q;

	logic [IDX_W-1:0]            row_red, up_in, row_dn, col_lf, col_rt;
	logic [LATTICE_SIDE-1:0]     rd_a, rd_b, wr_word;
	logic                        s_bit, is_upd, flip, new_bit;
	logic [3:0]                  nb;
	logic [2:0]                  k;
	logic [isfu_pkg::PROB_W-1:0] thr;
	logic                        ram_we, ram_re_a;
	logic [IDX_W-1:0]            ram_waddr, ram_raddr_a;
	logic [LATTICE_SIDE-1:0]     ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_minus8_q <= isfu_pkg::PROB_MINUS8_RST;
			prob_minus4_q <= isfu_pkg::PROB_MINUS4_RST;
			prob_plus4_q  <= isfu_pkg::PROB_PLUS4_RST;
			prob_plus8_q  <= isfu_pkg::PROB_PLUS8_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				isfu_pkg::REG_MINUS8: prob_minus8_q <= cfg_data;
				isfu_pkg::REG_MINUS4: prob_minus4_q <= cfg_data;
				isfu_pkg::REG_PLUS4:  prob_plus4_q  <= cfg_data;
				isfu_pkg::REG_PLUS8:  prob_plus8_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= (clr_cnt_q == LAST) ? '0 : clr_cnt_q + 1'b1;
		end
	end

	assign status.clr_last = (clr_cnt_q == LAST);

	assign row_red = red_tbl[row];
	assign up_in   = (row_red == '0) ? LAST : row_red - 1'b1;
	assign row_dn  = (row_q == LAST) ? '0 : row_q + 1'b1;
	assign col_lf  = (col_q == '0) ? LAST : col_q - 1'b1;
	assign col_rt  = (col_q == LAST) ? '0 : col_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= operation;
			row_q     <= row_red;
			col_q     <= red_tbl[column];
			spin_in_q <= spin_in;
			rnd_q     <= random_value;
		end
		// port A still holds the row above when the row below is requested
		if (cmd.rd_dn) begin
			up_q <= rd_a;
		end
		if (cmd.exec) begin
			spin_out_q <= new_bit;
			flipped_q  <= flip;
			de_q       <= is_upd ? $signed(isfu_pkg::DE_W'(5'd8 - {k, 2'b00})) : '0;
		end
	end

	// port B holds the addressed row, port A the row below during an update
	always_comb begin
		s_bit = rd_b[col_q];
		nb    = {up_q[col_q], rd_a[col_q], rd_b[col_lf], rd_b[col_rt]};
		k     = 3'($countones(nb ^ {4{s_bit}}));
		case (k)
			3'd0:    thr = prob_plus8_q;
			3'd1:    thr = prob_plus4_q;
			3'd3:    thr = prob_minus4_q;
			3'd4:    thr = prob_minus8_q;
			default: thr = isfu_pkg::PROB_ZERO;
		endcase
		is_upd  = (op_q == isfu_pkg::OP_UPDATE);
		flip    = is_upd && (rnd_q < thr);
		new_bit = (op_q == isfu_pkg::OP_WRITE) ? spin_in_q : (s_bit ^ flip);
		wr_word = rd_b;
		wr_word[col_q] = new_bit;
	end

	assign ram_we      = cmd.clr || (cmd.exec && (is_upd || op_q == isfu_pkg::OP_WRITE));
	assign ram_waddr   = cmd.clr ? clr_cnt_q : row_q;
	assign ram_wdata   = cmd.clr ? '0 : wr_word;
	assign ram_re_a    = cmd.accept || cmd.rd_dn;
	assign ram_raddr_a = cmd.accept ? up_in : row_dn;

	isfu_ram #(
		.WIDTH(LATTICE_SIDE),
		.DEPTH(LATTICE_SIDE)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re_a    (ram_re_a),
		.raddr_a (ram_raddr_a),
		.rdata_a (rd_a),
		.re_b    (cmd.accept),
		.raddr_b (row_red),
		.rdata_b (rd_b)
	);

	assign spin_out      = spin_out_q;
	assign flipped       = flipped_q;
	assign energy_change = de_q;

endmodule

@@ hw/rtl/isfu_ctrl.sv @@
module isfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op_update,
	output logic              out_valid,
	input  logic              out_ready,
	output isfu_pkg::cmd_t    cmd,
	input  isfu_pkg::status_t status
);

	isfu_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isfu_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			isfu_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = isfu_pkg::ST_IDLE;
				end
			end
			isfu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = op_update ? isfu_pkg::ST_READ_DN : isfu_pkg::ST_EXEC;
				end
			end
			isfu_pkg::ST_READ_DN: begin
				cmd.rd_dn = 1'b1;
				state_d   = isfu_pkg::ST_EXEC;
			end
			isfu_pkg::ST_EXEC: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.exec = 1'b1;
					state_d  = isfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = isfu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_upd_reads_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && op_update) |=> (state_q == isfu_pkg::ST_READ_DN))
		else $error("update beat not followed by lower row read");

	a_dn_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isfu_pkg::ST_READ_DN) |=> (state_q == isfu_pkg::ST_EXEC))
		else $error("lower row read not followed by execute");

	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.exec))
		else $error("result raised without execute");

	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isfu_pkg::ST_EXEC && out_valid_q && !out_ready)
		|=> (state_q == isfu_pkg::ST_EXEC && out_valid_q))
		else $error("execute left while result still pending");
`endif

endmodule

@@ hw/rtl/ising_site_flip_update.sv @@
// Update: ST_READ_DN reads the row below, then ST_EXEC registers the result; write
// and read go straight to ST_EXEC, which waits while the output register is full. No
// new beat is taken before that. The steps follow from the three lattice rows an
// update needs from the two-read-port row memory, then the addressed row's write-back.
// Reset: threshold registers take their defaults; a clearing pass then writes
// LATTICE_SIDE zero rows, one a cycle, and no input beat is taken until it ends.
module ising_site_flip_update #(
	parameter int LATTICE_SIDE = isfu_pkg::LATTICE_SIDE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [isfu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [isfu_pkg::PROB_W-1:0]        cfg_data,
	isfu_in_if.sink                            in_ch,
	isfu_out_if.source                         out_ch
);

	isfu_pkg::cmd_t    cmd;
	isfu_pkg::status_t status;

	isfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.op_update (in_ch.operation == isfu_pkg::OP_UPDATE),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	isfu_dp #(
		.LATTICE_SIDE(LATTICE_SIDE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.operation     (in_ch.operation),
		.row           (in_ch.row),
		.column        (in_ch.column),
		.spin_in       (in_ch.spin_in),
		.random_value  (in_ch.random_value),
		.spin_out      (out_ch.spin_out),
		.flipped       (out_ch.flipped),
		.energy_change (out_ch.energy_change)
	);

endmodule
